// ===== hdl/mtg_pkg.sv =====
// Shared constants, types and the tempering function of the MT19937 generator.
// Used by the controller, the datapath and the top level.
package mtg_pkg;

  localparam int STATE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int LAST_INDEX   = STATE_DEPTH - 1;
  localparam int FAR_WRAP     = STATE_DEPTH - TWIST_OFFSET;
  localparam int UNSEEDED     = STATE_DEPTH + 1;
  localparam int ADDR_W       = $clog2(STATE_DEPTH);
  localparam int IDX_W        = $clog2(STATE_DEPTH + 2);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  typedef struct packed {
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic tw_start;
    logic tw_load;
    logic tw_rd;
    logic tw_calc;
    logic draw_load;
  } cmd_t;

  typedef struct packed {
    logic unseeded;
    logic at_end;
    logic cnt_last;
    logic out_free;
  } status_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mtg_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/mtg_ctrl.sv =====
// Controller state machine: sequences seeding, twisting and drawing.
// Depends on mtg_pkg for the command and status types.
module mtg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             restart,
  input  mtg_pkg::status_t status,
  output mtg_pkg::cmd_t    cmd
);
  import mtg_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SEED_INIT = 10'b00_0000_0010,
    S_SEED_MUL  = 10'b00_0000_0100,
    S_SEED_ADD  = 10'b00_0000_1000,
    S_TW_START  = 10'b00_0001_0000,
    S_TW_LOAD   = 10'b00_0010_0000,
    S_TW_RD     = 10'b00_0100_0000,
    S_TW_CALC   = 10'b00_1000_0000,
    S_READ      = 10'b01_0000_0000,
    S_DRAW      = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (restart || status.unseeded) begin
            state_next = S_SEED_INIT;
          end else if (status.at_end) begin
            state_next = S_TW_START;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_SEED_INIT: begin
        cmd.seed_init = 1'b1;
        state_next    = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_next   = status.cnt_last ? S_TW_START : S_SEED_MUL;
      end
      S_TW_START: begin
        cmd.tw_start = 1'b1;
        state_next   = S_TW_LOAD;
      end
      S_TW_LOAD: begin
        cmd.tw_load = 1'b1;
        state_next  = S_TW_RD;
      end
      S_TW_RD: begin
        cmd.tw_rd  = 1'b1;
        state_next = S_TW_CALC;
      end
      S_TW_CALC: begin
        cmd.tw_calc = 1'b1;
        state_next  = status.cnt_last ? S_READ : S_TW_RD;
      end
      S_READ: begin
        state_next = S_DRAW;
      end
      S_DRAW: begin
        if (status.out_free) begin
          cmd.draw_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mtg_datapath.sv =====
// Datapath: seed register, state memory, seeding multiplier, twist and temper logic.
// Depends on mtg_pkg and instantiates mtg_ram.
module mtg_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_wr_en,
  input  logic [31:0]      seed,
  input  mtg_pkg::cmd_t    cmd,
  output mtg_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      random_word
);
  import mtg_pkg::*;

  logic [31:0]       seed_value;
  logic [IDX_W-1:0]  read_index;
  logic [ADDR_W-1:0] cnt;
  logic [31:0]       prev;
  logic [31:0]       prod;
  logic [31:0]       carry;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [31:0]       rdata_a;
  logic [31:0]       rdata_b;

  logic [ADDR_W-1:0] cnt_succ;
  logic [31:0]       seed_word;
  logic [31:0]       mix;
  logic [31:0]       twist_y;
  logic [31:0]       twist_word;

  assign cnt_succ  = (cnt == ADDR_W'(LAST_INDEX)) ? '0 : cnt + 1'b1;
  assign seed_word = prod + 32'(cnt);
  assign mix       = prev ^ (prev >> 30);
  assign twist_y   = {carry[31], rdata_a[30:0]};
  assign twist_word = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);

  always_comb begin
    if (cmd.tw_start) begin
      raddr_a = '0;
    end else if (cmd.tw_rd) begin
      raddr_a = cnt_succ;
    end else begin
      raddr_a = read_index[ADDR_W-1:0];
    end
    if (cnt < ADDR_W'(FAR_WRAP)) begin
      raddr_b = cnt + ADDR_W'(TWIST_OFFSET);
    end else begin
      raddr_b = cnt - ADDR_W'(FAR_WRAP);
    end
  end

  always_comb begin
    we = cmd.seed_init | cmd.seed_add | cmd.tw_calc;
    if (cmd.seed_init) begin
      waddr = '0;
      wdata = seed_value;
    end else if (cmd.seed_add) begin
      waddr = cnt;
      wdata = seed_word;
    end else begin
      waddr = cnt;
      wdata = twist_word;
    end
  end

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(STATE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= SEED_RESET;
      read_index <= IDX_W'(UNSEEDED);
      out_valid  <= 1'b0;
    end else begin
      if (seed_wr_en) begin
        seed_value <= seed;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.draw_load) begin
        out_valid  <= 1'b1;
        read_index <= read_index + 1'b1;
      end
      if (cmd.tw_calc && status.cnt_last) begin
        read_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      cnt  <= ADDR_W'(1);
      prev <= seed_value;
    end
    if (cmd.seed_mul) begin
      prod <= 32'(SEED_MULT * mix);
    end
    if (cmd.seed_add) begin
      prev <= seed_word;
      cnt  <= cnt + 1'b1;
    end
    if (cmd.tw_start) begin
      cnt <= '0;
    end
    if (cmd.tw_load || cmd.tw_calc) begin
      carry <= rdata_a;
    end
    if (cmd.tw_calc) begin
      cnt <= cnt_succ;
    end
    if (cmd.draw_load) begin
      random_word <= temper(rdata_a);
    end
  end

  always_comb begin
    status.unseeded = read_index > IDX_W'(STATE_DEPTH);
    status.at_end   = read_index == IDX_W'(STATE_DEPTH);
    status.cnt_last = cnt == ADDR_W'(LAST_INDEX);
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// MT19937 generator top level. A plain draw reads the state memory in S_READ, then registers
// the tempered word in S_DRAW, which waits while the output is held; a new request is taken
// only after the previous word is loaded. A twist adds S_TW_RD and S_TW_CALC for each word, and
// seeding adds S_SEED_MUL and S_SEED_ADD for each later word (one 32x32 multiply per word)
// before the twist. Reset clears the seed to 5489 and marks the block unseeded; the RAM is not cleared.
// Depends on mtg_pkg, mtg_ctrl and mtg_datapath.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  input  logic        seed_wr_en,
  input  logic [31:0] seed
);
  import mtg_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .status   (status),
    .cmd      (cmd)
  );

  mtg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .seed_wr_en  (seed_wr_en),
    .seed        (seed),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word)
  );

endmodule

// ===== bench/tb_mersenne_twister_generator.sv =====
// Self-checking testbench for the MT19937 generator: random request traffic with reseeds,
// seed register changes and handshake stalls, checked against an in-bench predictor.
// Depends on the mersenne_twister_generator RTL only.
module tb_mersenne_twister_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MT_N            = 624;
  localparam int          MT_SHIFT        = 397;
  localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
  localparam logic [31:0] MT_MULT         = 32'd1812433253;
  localparam logic [31:0] MT_TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] MT_TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] MT_SEED_DEFAULT = 32'd5489;
  localparam int          DRAW_LATENCY    = 3;
  localparam int          WATCHDOG_LIMIT  = 12000;

  class mt_scoreboard;
    logic [31:0] words [MT_N];
    int unsigned cursor;
    logic [31:0] seed_word;
    logic [31:0] expected_words [$];
    int errors;
    int checked;

    function new();
      cursor = MT_N + 1;
      seed_word = MT_SEED_DEFAULT;
      errors = 0;
      checked = 0;
    endfunction

    function void load_seed(logic [31:0] value);
      seed_word = value;
    endfunction

    function void note_request(bit reseed);
      logic [31:0] y;
      logic [31:0] w;
      int i;
      int nxt;
      int far;
      if (reseed || cursor > MT_N) begin
        words[0] = seed_word;
        for (i = 1; i < MT_N; i++) begin
          words[i] = MT_MULT * (words[i-1] ^ (words[i-1] >> 30)) + 32'(i);
        end
        cursor = MT_N;
      end
      if (cursor >= MT_N) begin
        for (i = 0; i < MT_N; i++) begin
          nxt = (i + 1) % MT_N;
          far = (i + MT_SHIFT) % MT_N;
          y = {words[i][31], words[nxt][30:0]};
          words[i] = words[far] ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'h0);
        end
        cursor = 0;
      end
      w = words[cursor];
      cursor++;
      w ^= w >> 11;
      w ^= (w << 7) & MT_TEMPER_B;
      w ^= (w << 15) & MT_TEMPER_C;
      w ^= w >> 18;
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [31:0] actual);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected random_word, expected none, actual %h", $time, actual);
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (actual !== want) begin
        errors++;
        $display("%0t: random_word mismatch, expected %h, actual %h", $time, want, actual);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] random_word;
  logic        seed_wr_en = 1'b0;
  logic [31:0] seed = 32'h0;

  mt_scoreboard sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int requests = 0;
  int reseeds = 0;
  int seed_settings = 0;

  mersenne_twister_generator u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .random_word(random_word),
    .seed_wr_en (seed_wr_en),
    .seed       (seed)
  );

  always #5 clk = ~clk;

  task automatic send_request(input bit flag);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    restart <= flag;
    do @(posedge clk); while (!in_ready);
    sb.note_request(flag);
    requests++;
    if (flag) reseeds++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAW_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    seed_wr_en <= 1'b1;
    seed <= value;
    @(posedge clk);
    seed_wr_en <= 1'b0;
    sb.load_seed(value);
    seed_settings++;
  endtask

  // Result side: checks each transfer and drives out_ready for the next edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_word(random_word);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_mersenne_twister_generator failed");
    $finish;
  end

  initial begin
    int phase;
    int count;
    int odds;
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first request seeds from the reset seed even without the restart flag.
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();

    // A new seed is ignored until the next restart.
    write_seed(32'h0000_0000);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();

    write_seed(32'hffff_ffff);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      count = (phase == 0) ? 700 : 270;
      odds = (phase == 0) ? 500 : 60;
      write_seed($urandom);
      for (i = 0; i < count; i++) begin
        // The long receiver hold lets the block fill up and push back on requests.
        if (phase == 0 && i == 10) hold_left = 400;
        if (phase == 2 && i == count / 2) wait_drained();
        send_request(i == 0 || $urandom_range(odds - 1) == 0);
      end
      wait_drained();
    end

    stall_pct = 0;
    wait_drained();
    if (sb.expected_words.size() != 0) begin
      sb.errors += sb.expected_words.size();
      $display("%0t: %0d expected words never arrived", $time, sb.expected_words.size());
    end
    $display("Ran %0d requests with %0d reseeds over %0d seed settings; %0d words checked.",
             requests, reseeds, seed_settings, sb.checked);
    $display("State twists, unseeded first draw and input/output stalls were exercised.");
    if (sb.errors == 0) begin
      $display("tb_mersenne_twister_generator passed");
    end else begin
      $display("tb_mersenne_twister_generator failed");
    end
    $finish;
  end

endmodule
